// ===== hw/rtl/edtd_pkg.sv =====
// Shared types and constants for the EDID timing descriptor decoder.
`timescale 1ns / 1ps

package edtd_pkg;

   localparam int unsigned DTD_START   = 54;
   localparam int unsigned DTD_LEN     = 18;
   localparam int unsigned DTD_KEEP    = 8;
   localparam int unsigned DTD_MAX     = 4;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned DIV_STEPS   = 40;

   // pixel clock comes in 10 kHz units; refresh is in milli-Hz
   localparam logic [23:0] PIX_SCALE = 24'd10_000_000;
   localparam logic [2:0]  COUNT_MAX = 3'd7;

   localparam logic KIND_MODE    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_DECODE  = 2'd1,
      CMD_SUMMARY = 2'd2
   } edtd_cmd_kind_type;

   typedef struct packed {
      edtd_cmd_kind_type             cmd_kind;
      logic [DTD_KEEP-1:0][7:0]      dtd_bytes;
   } edtd_cmd_type;

   typedef struct packed {
      logic         valid;
      edtd_cmd_type cmd;
   } edtd_qlink_type;

endpackage

// ===== hw/rtl/edtd_if.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
`timescale 1ns / 1ps

interface edtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic [6:0] byte_offset;

   modport source (output valid, byte_value, byte_offset, input ready);
   modport sink   (input valid, byte_value, byte_offset, output ready);
endinterface

interface edtd_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [11:0] active_width;
   logic [11:0] active_height;
   logic [31:0] refresh_millihertz;
   logic [1:0]  mode_slot;
   logic        slot_kept;
   logic [2:0]  valid_mode_count;

   modport source (output valid, result_kind, active_width, active_height,
                   refresh_millihertz, mode_slot, slot_kept, valid_mode_count,
                   input ready);
   modport sink   (input valid, result_kind, active_width, active_height,
                   refresh_millihertz, mode_slot, slot_kept, valid_mode_count,
                   output ready);
endinterface

// ===== hw/rtl/edtd_front.sv =====
// Front end: accepts EDID bytes, captures descriptor bytes and issues commands.
`timescale 1ns / 1ps

module edtd_front #(
   parameter int unsigned EDID_BYTES = 128
) (
   input  logic                     clock,
   edtd_req_if.sink                 req,
   input  logic                     q_full,
   output edtd_pkg::edtd_qlink_type push
);
   import edtd_pkg::*;

   localparam int unsigned DTD_COUNT   = (EDID_BYTES - DTD_START) / DTD_LEN;
   localparam logic [6:0]  OFFSET_LAST = 7'(EDID_BYTES - 1);
   localparam logic [2:0]  POS_LAST    = 3'(DTD_KEEP - 1);

   logic [7:0] dtd_ff [DTD_KEEP];
   logic       accept;
   logic       in_dtd;
   logic [2:0] pos;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // only descriptors that fit completely inside the block count
   always_comb begin
      in_dtd = 1'b0;
      pos    = '0;
      for (int d = 0; d < DTD_MAX; d++) begin
         if (d < DTD_COUNT &&
             req.byte_offset >= 7'(DTD_START + d * DTD_LEN) &&
             req.byte_offset <  7'(DTD_START + d * DTD_LEN + DTD_KEEP)) begin
            in_dtd = 1'b1;
            pos    = 3'(req.byte_offset - 7'(DTD_START + d * DTD_LEN));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && in_dtd) begin
         dtd_ff[pos] <= req.byte_value;
      end
   end

   always_comb begin
      push.valid        = 1'b0;
      push.cmd.cmd_kind = CMD_CLEAR;
      for (int i = 0; i < DTD_KEEP; i++) begin
         push.cmd.dtd_bytes[i] = dtd_ff[i];
      end
      // last byte goes straight into the command
      push.cmd.dtd_bytes[DTD_KEEP-1] = req.byte_value;
      if (accept) begin
         if (req.byte_offset == '0) begin
            push.valid        = 1'b1;
            push.cmd.cmd_kind = CMD_CLEAR;
         end else if (in_dtd && pos == POS_LAST) begin
            push.valid        = 1'b1;
            push.cmd.cmd_kind = CMD_DECODE;
         end else if (req.byte_offset == OFFSET_LAST) begin
            push.valid        = 1'b1;
            push.cmd.cmd_kind = CMD_SUMMARY;
         end
      end
   end

endmodule

// ===== hw/rtl/edtd_queue.sv =====
// Two-entry command queue between the front end and the decode engine.
`timescale 1ns / 1ps

module edtd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  edtd_pkg::edtd_qlink_type push,
   input  logic                     pop,
   output logic                     full,
   output edtd_pkg::edtd_qlink_type head
);
   import edtd_pkg::*;

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   edtd_cmd_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full       = count_ff == (PTR_W+1)'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slot_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full || pop)
      else $error("command pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("command popped from an empty queue");

endmodule

// ===== hw/rtl/edtd_back.sv =====
// Decode engine: timing count, size decode, refresh divide and result register.
`timescale 1ns / 1ps

module edtd_back #(
   parameter int unsigned MODE_CAPACITY = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  edtd_pkg::edtd_qlink_type head,
   output logic                     pop,
   edtd_rsp_if.source               rsp
);
   import edtd_pkg::*;

   localparam int unsigned STEP_W = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MUL  = 3'b010,
      ST_DIV  = 3'b100
   } edtd_back_state_type;

   edtd_back_state_type state_ff, state_in;
   logic [2:0]          count_ff, count_in;
   logic                out_valid_ff, out_valid_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic        out_kind_ff, out_kind_in;
   logic [11:0] out_width_ff, out_width_in;
   logic [11:0] out_height_ff, out_height_in;
   logic [31:0] out_refresh_ff, out_refresh_in;
   logic [1:0]  out_slot_ff, out_slot_in;
   logic        out_kept_ff, out_kept_in;
   logic [2:0]  out_count_ff, out_count_in;

   logic [11:0] hact_ff, hact_in;
   logic [11:0] vact_ff, vact_in;
   logic [12:0] htot_ff, htot_in;
   logic [12:0] vtot_ff, vtot_in;
   logic [15:0] clk_ff, clk_in;
   logic [25:0] den_ff, den_in;
   logic [39:0] num_ff, num_in;
   logic [25:0] rem_ff, rem_in;

   // fields of the descriptor at the head of the queue
   logic [15:0] d_clk;
   logic [11:0] d_hact, d_hblk, d_vact, d_vblk;
   logic        d_ok;

   // one restoring divide step
   logic [26:0] div_shift, div_trial;
   logic        div_ge;

   assign d_clk  = {head.cmd.dtd_bytes[1], head.cmd.dtd_bytes[0]};
   assign d_hact = {head.cmd.dtd_bytes[4][7:4], head.cmd.dtd_bytes[2]};
   assign d_hblk = {head.cmd.dtd_bytes[4][3:0], head.cmd.dtd_bytes[3]};
   assign d_vact = {head.cmd.dtd_bytes[7][7:4], head.cmd.dtd_bytes[5]};
   assign d_vblk = {head.cmd.dtd_bytes[7][3:0], head.cmd.dtd_bytes[6]};
   assign d_ok   = d_clk != '0 && d_hact != '0 && d_vact != '0;

   assign div_shift = {rem_ff, num_ff[39]};
   assign div_trial = div_shift - {1'b0, den_ff};
   assign div_ge    = div_shift >= {1'b0, den_ff};

   assign pop = state_ff == ST_IDLE && !out_valid_ff && head.valid;

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      out_valid_in   = out_valid_ff;
      step_in        = step_ff;
      out_kind_in    = out_kind_ff;
      out_width_in   = out_width_ff;
      out_height_in  = out_height_ff;
      out_refresh_in = out_refresh_ff;
      out_slot_in    = out_slot_ff;
      out_kept_in    = out_kept_ff;
      out_count_in   = out_count_ff;
      hact_in        = hact_ff;
      vact_in        = vact_ff;
      htot_in        = htot_ff;
      vtot_in        = vtot_ff;
      clk_in         = clk_ff;
      den_in         = den_ff;
      num_in         = num_ff;
      rem_in         = rem_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (head.cmd.cmd_kind)
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_SUMMARY: begin
                     out_valid_in   = 1'b1;
                     out_kind_in    = KIND_SUMMARY;
                     out_width_in   = '0;
                     out_height_in  = '0;
                     out_refresh_in = '0;
                     out_slot_in    = '0;
                     out_kept_in    = 1'b0;
                     out_count_in   = count_ff;
                     count_in       = '0;
                  end
                  CMD_DECODE: begin
                     // skipped descriptors leave no trace
                     if (d_ok) begin
                        hact_in  = d_hact;
                        vact_in  = d_vact;
                        htot_in  = {1'b0, d_hact} + {1'b0, d_hblk};
                        vtot_in  = {1'b0, d_vact} + {1'b0, d_vblk};
                        clk_in   = d_clk;
                        state_in = ST_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            den_in   = htot_ff * vtot_ff;
            num_in   = clk_ff * PIX_SCALE;
            rem_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_ge ? div_trial[25:0] : div_shift[25:0];
            num_in  = {num_ff[38:0], div_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               out_valid_in   = 1'b1;
               out_kind_in    = KIND_MODE;
               out_width_in   = hact_ff;
               out_height_in  = vact_ff;
               out_refresh_in = num_in[31:0];
               out_slot_in    = count_ff[1:0];
               out_kept_in    = count_ff < 3'(MODE_CAPACITY);
               count_in       = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
               out_count_in   = count_in;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      out_kind_ff    <= out_kind_in;
      out_width_ff   <= out_width_in;
      out_height_ff  <= out_height_in;
      out_refresh_ff <= out_refresh_in;
      out_slot_ff    <= out_slot_in;
      out_kept_ff    <= out_kept_in;
      out_count_ff   <= out_count_in;
      hact_ff        <= hact_in;
      vact_ff        <= vact_in;
      htot_ff        <= htot_in;
      vtot_ff        <= vtot_in;
      clk_ff         <= clk_in;
      den_ff         <= den_in;
      num_ff         <= num_in;
      rem_ff         <= rem_in;
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.result_kind        = out_kind_ff;
   assign rsp.active_width       = out_width_ff;
   assign rsp.active_height      = out_height_ff;
   assign rsp.refresh_millihertz = out_refresh_ff;
   assign rsp.mode_slot          = out_slot_ff;
   assign rsp.slot_kept          = out_kept_ff;
   assign rsp.valid_mode_count   = out_count_ff;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> den_ff != '0)
      else $error("divide started with a zero total");

   a_busy_no_result: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !out_valid_ff)
      else $error("engine busy while a result is pending");

   a_mode_sane: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.result_kind == KIND_MODE |->
         rsp.valid_mode_count != '0 && rsp.active_width != '0 &&
         rsp.active_height != '0)
      else $error("mode result with zero size or zero count");

endmodule

// ===== hw/rtl/edid_timing_descriptor_decoder.sv =====
// Order: a mode result follows the eighth descriptor byte transfer through the queue,
// the queue pop, the multiply state and 40 divide steps; a summary follows its pop.
// Throughput: one byte per cycle while the two-entry command queue has room; the
// bit-serial divider holds the engine for each valid descriptor, as does a pending result.
// Reset: synchronous, clears the queue, the timing count and the result valid flag;
// captured descriptor bytes and result fields are not reset.
`timescale 1ns / 1ps

module edid_timing_descriptor_decoder #(
   parameter int unsigned EDID_BYTES    = 128,
   parameter int unsigned MODE_CAPACITY = 4
) (
   input  logic        clock,
   input  logic        reset,
   edtd_req_if.sink    req_chan,
   edtd_rsp_if.source  rsp_chan
);
   import edtd_pkg::*;

   edtd_qlink_type push_link;
   edtd_qlink_type head_link;
   logic           q_full;
   logic           q_pop;

   edtd_front #(
      .EDID_BYTES (EDID_BYTES)
   ) u_front (
      .clock  (clock),
      .req    (req_chan),
      .q_full (q_full),
      .push   (push_link)
   );

   edtd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push_link),
      .pop   (q_pop),
      .full  (q_full),
      .head  (head_link)
   );

   edtd_back #(
      .MODE_CAPACITY (MODE_CAPACITY)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head_link),
      .pop   (q_pop),
      .rsp   (rsp_chan)
   );

endmodule

// ===== dv/edid_timing_descriptor_decoder_tb.sv =====
// Self-checking testbench for the EDID detailed timing descriptor decoder.
`timescale 1ns / 1ps

module edid_timing_descriptor_decoder_tb;
   import edtd_pkg::*;

   localparam int unsigned EDID_BYTES    = 128;
   localparam int unsigned MODE_CAPACITY = 4;
   localparam int unsigned WATCHDOG_MAX  = 3000;
   localparam int unsigned DRAIN_CYCLES  = 60;
   localparam int unsigned HOLD_CYCLES   = 500;
   localparam int unsigned HOLD_AFTER    = 400;

   typedef struct packed {
      logic        kind;
      logic [11:0] width;
      logic [11:0] height;
      logic [31:0] refresh;
      logic [1:0]  slot;
      logic        kept;
      logic [2:0]  count;
   } edid_result_t;

   typedef struct packed {
      logic [7:0] value;
      logic [6:0] offs;
      logic [1:0] phase;
   } edid_byte_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   edtd_req_if req_chan ();
   edtd_rsp_if rsp_chan ();

   edid_timing_descriptor_decoder #(
      .EDID_BYTES    (EDID_BYTES),
      .MODE_CAPACITY (MODE_CAPACITY)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   edid_byte_t   byte_queue [$];
   edid_result_t expected_modes [$];

   // predictor state
   logic [7:0] dtd_shadow [8];
   logic [2:0] found_count = '0;

   // generator bookkeeping
   bit [7:0]    gen_written = '0;
   int unsigned gen_phase = 0;
   int unsigned queued_items = 0;
   int unsigned planned_results = 0;

   bit          req_taken = 1'b0;
   int unsigned cur_phase = 0;
   int unsigned accepted_bytes = 0;
   int unsigned hold_left = 0;
   bit          pressure_done = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned errors = 0;

   function automatic bit predict_byte(input logic [7:0] value, input logic [6:0] offs,
                                       output edid_result_t res);
      int unsigned rel, idx, pos, dtd_end;
      logic [15:0] clk10k;
      logic [11:0] hact, hblk, vact, vblk;
      logic [63:0] num, denom;
      res = '0;
      if (offs == 0)
         found_count = '0;
      if (offs >= EDID_BYTES)
         return 1'b0;
      if (offs >= DTD_START) begin
         rel     = offs - DTD_START;
         idx     = rel / DTD_LEN;
         pos     = rel % DTD_LEN;
         dtd_end = DTD_START + (idx + 1) * DTD_LEN;
         if (dtd_end <= EDID_BYTES && pos < DTD_KEEP) begin
            dtd_shadow[pos[2:0]] = value;
            if (pos == DTD_KEEP - 1) begin
               clk10k = {dtd_shadow[1], dtd_shadow[0]};
               hact   = {dtd_shadow[4][7:4], dtd_shadow[2]};
               hblk   = {dtd_shadow[4][3:0], dtd_shadow[3]};
               vact   = {dtd_shadow[7][7:4], dtd_shadow[5]};
               vblk   = {dtd_shadow[7][3:0], dtd_shadow[6]};
               if (clk10k == 0 || hact == 0 || vact == 0)
                  return 1'b0;
               num   = 64'(clk10k) * 64'(PIX_SCALE);
               denom = (64'(hact) + 64'(hblk)) * (64'(vact) + 64'(vblk));
               res.kind    = KIND_MODE;
               res.width   = hact;
               res.height  = vact;
               res.refresh = 32'(num / denom);
               res.slot    = found_count[1:0];
               res.kept    = (found_count < MODE_CAPACITY);
               if (found_count < COUNT_MAX)
                  found_count = found_count + 3'd1;
               res.count = found_count;
               return 1'b1;
            end
         end
      end
      if (offs == EDID_BYTES - 1) begin
         res.kind    = KIND_SUMMARY;
         res.count   = found_count;
         found_count = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic queue_byte(input logic [7:0] value, input int unsigned offs);
      int unsigned pos;
      bit in_dtd;
      edid_byte_t it;
      in_dtd = 1'b0;
      pos    = 0;
      if (offs >= DTD_START) begin
         pos    = (offs - DTD_START) % DTD_LEN;
         in_dtd = pos < DTD_KEEP &&
                  DTD_START + ((offs - DTD_START) / DTD_LEN + 1) * DTD_LEN <= EDID_BYTES;
      end
      // a decode must never read a descriptor byte that was never captured
      if (in_dtd && pos == DTD_KEEP - 1 && (gen_written | 8'h80) != 8'hFF)
         return;
      if (in_dtd)
         gen_written[pos[2:0]] = 1'b1;
      if ((in_dtd && pos == DTD_KEEP - 1) || offs == EDID_BYTES - 1)
         planned_results++;
      queued_items++;
      it.value = value;
      it.offs  = offs[6:0];
      it.phase = gen_phase[1:0];
      byte_queue.push_back(it);
   endtask

   function automatic logic [7:0][7:0] random_timing();
      logic [7:0][7:0] b;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      for (int i = 0; i < 8; i++)
         b[i] = 8'($urandom_range(0, 255));
      if (pick < 10) begin
         b[0] = '0;
         b[1] = '0;
      end else if (pick < 18) begin
         b[2]      = '0;
         b[4][7:4] = '0;
      end else if (pick < 26) begin
         b[5]      = '0;
         b[7][7:4] = '0;
      end else if (pick < 40) begin
         for (int i = 0; i < 8; i++)
            case ($urandom_range(0, 2))
               0:       b[i] = 8'h00;
               1:       b[i] = 8'h01;
               default: b[i] = 8'hFF;
            endcase
      end
      return b;
   endfunction

   task automatic send_descriptor(input int unsigned slot, input logic [7:0][7:0] b,
                                  input int unsigned trail);
      int unsigned base, pos;
      base = DTD_START + slot * DTD_LEN;
      for (int i = 0; i < DTD_KEEP; i++)
         queue_byte(b[i], base + i);
      pos = DTD_KEEP - 1;
      repeat (trail) begin
         pos = pos + $urandom_range(1, 4);
         if (pos < DTD_LEN)
            queue_byte(8'($urandom_range(0, 255)), base + pos);
      end
   endtask

   task automatic build_stimulus();
      logic [7:0][7:0] dtds [4];
      int unsigned kind, offs, rel;
      // directed: extremes, truncated refresh, ignored bytes, skipped descriptor
      queue_byte(8'hFF, 0);
      send_descriptor(0, '1, 0);
      send_descriptor(1, 64'h0000_0100_0001_0001, 0);
      queue_byte(8'hFF, 90);
      queue_byte(8'hFF, 91);
      queue_byte(8'h00, 97);
      queue_byte(8'h55, 98);
      queue_byte(8'h00, 108);
      queue_byte(8'h00, 109);
      queue_byte(8'h00, 115);
      queue_byte(8'h00, EDID_BYTES - 1);

      queued_items    = 0;
      planned_results = 0;
      while (queued_items < 900 || planned_results < 60) begin
         gen_phase = (queued_items / 150) % 4;
         kind = $urandom_range(0, 99);
         if (kind < 60) begin
            queue_byte(8'($urandom_range(0, 255)), 0);
            offs = 0;
            repeat ($urandom_range(0, 3)) begin
               offs = offs + $urandom_range(1, 12);
               if (offs < DTD_START)
                  queue_byte(8'($urandom_range(0, 255)), offs);
            end
            for (int s = 0; s < DTD_MAX; s++)
               if ($urandom_range(0, 99) < 85)
                  send_descriptor(s, random_timing(), $urandom_range(0, 2));
            if ($urandom_range(0, 1))
               queue_byte(8'($urandom_range(0, 255)), EDID_BYTES - 2);
            queue_byte(8'($urandom_range(0, 255)), EDID_BYTES - 1);
         end else if (kind < 75) begin
            for (int s = 0; s < DTD_MAX; s++)
               dtds[s] = random_timing();
            for (int o = 0; o < EDID_BYTES; o++) begin
               rel = o - DTD_START;
               if (o >= DTD_START && rel % DTD_LEN < DTD_KEEP && rel / DTD_LEN < DTD_MAX)
                  queue_byte(dtds[rel / DTD_LEN][rel % DTD_LEN], o);
               else
                  queue_byte(8'($urandom_range(0, 255)), o);
            end
         end else if (kind < 90) begin
            // many descriptors with no start of block: drives the count into saturation
            repeat ($urandom_range(6, 10))
               send_descriptor($urandom_range(0, DTD_MAX - 1), random_timing(), 0);
            if ($urandom_range(0, 1))
               queue_byte(8'($urandom_range(0, 255)), EDID_BYTES - 1);
         end else begin
            repeat ($urandom_range(5, 20))
               queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, EDID_BYTES - 1));
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // byte driver
   always @(negedge clock) begin : byte_driver
      edid_byte_t item;
      int unsigned idle_pct;
      if (reset) begin
         req_chan.valid       <= 1'b0;
         req_chan.byte_value  <= '0;
         req_chan.byte_offset <= '0;
      end else if (!req_chan.valid || req_taken) begin
         req_taken = 1'b0;
         idle_pct  = 0;
         if (byte_queue.size() != 0)
            case (byte_queue[0].phase)
               2'd1:    idle_pct = 53;
               2'd3:    idle_pct = 31;
               default: idle_pct = 0;
            endcase
         if (byte_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            item      = byte_queue.pop_front();
            cur_phase = 32'(item.phase);
            req_chan.valid       <= 1'b1;
            req_chan.byte_value  <= item.value;
            req_chan.byte_offset <= item.offs;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off so the command queue backs up
   always @(negedge clock) begin : rsp_receiver
      int unsigned stall_pct;
      stall_pct = (cur_phase == 2) ? 53 : (cur_phase == 3) ? 31 : 0;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (!pressure_done && accepted_bytes >= HOLD_AFTER) begin
         pressure_done = 1'b1;
         hold_left      = HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // transfer monitor and checker
   always @(posedge clock) begin : transfer_monitor
      edid_result_t pred, got, want;
      bit busy;
      if (!reset) begin
         busy = 1'b0;
         if (req_chan.valid && req_chan.ready) begin
            busy      = 1'b1;
            req_taken = 1'b1;
            accepted_bytes++;
            if (predict_byte(req_chan.byte_value, req_chan.byte_offset, pred))
               expected_modes.push_back(pred);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            busy = 1'b1;
            got  = '{rsp_chan.result_kind, rsp_chan.active_width, rsp_chan.active_height,
                     rsp_chan.refresh_millihertz, rsp_chan.mode_slot, rsp_chan.slot_kept,
                     rsp_chan.valid_mode_count};
            if (expected_modes.size() == 0) begin
               errors++;
               if (errors <= 40)
                  $display("%0t: unexpected result: expected none, actual %p", $time, got);
            end else begin
               want = expected_modes.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(got.kind));
               check_field("active_width", 32'(want.width), 32'(got.width));
               check_field("active_height", 32'(want.height), 32'(got.height));
               check_field("refresh_millihertz", want.refresh, got.refresh);
               check_field("mode_slot", 32'(want.slot), 32'(got.slot));
               check_field("slot_kept", 32'(want.kept), 32'(got.kept));
               check_field("valid_mode_count", 32'(want.count), 32'(got.count));
            end
         end
         quiet_cycles = busy ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (byte_queue.size() != 0 || req_chan.valid || expected_modes.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
